// File: rtl/nbe_pkg.sv
// Shared types and constants for the nested blob extractor.
package nbe_pkg;

    localparam int POS_BITS_DEF    = 28;
    localparam int VARINT_MAX_DEF  = 4;
    localparam int BYTE_W          = 8;
    localparam int STATUS_W        = 3;
    localparam int OUT_TDATA_W     = 16;

    // Wire type and field numbers of interest
    localparam logic [2:0] WIRE_LEN     = 3'd2;
    localparam int FN_V1_LAYER          = 2;
    localparam int FN_LAYER             = 100;
    localparam int FN_V1_VALUE          = 5;
    localparam int FN_V1_BLOB           = 6;
    localparam int FN_V1_FIXED          = 7;
    localparam int FN_LAYER_BLOB        = 7;
    localparam int FN_BLOB_DATA         = 5;
    localparam int FIXED32_LEN          = 4;

    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_SKIP       = 3'd0,
        ACT_EMIT       = 3'd1,
        ACT_PUSH_V1    = 3'd2,
        ACT_PUSH_LAYER = 3'd3,
        ACT_PUSH_BLOB  = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_OK      = 3'd1,
        ST_VARINT  = 3'd2,
        ST_WIRE    = 3'd3,
        ST_FIELD   = 3'd4,
        ST_OVERRUN = 3'd5
    } status_t;

    localparam logic [1:0] LVL_TOP   = 2'd0;
    localparam logic [1:0] LVL_LAYER = 2'd1;
    localparam logic [1:0] LVL_BLOB  = 2'd2;

    // Parser control state
    typedef struct packed {
        logic [1:0] level;
        logic       layer_kind;   // 0 V1 layer, 1 Layer
        phase_t     phase;
        act_t       pending;
        logic       emit_payload;
        logic       finished;
        status_t    status;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        level:        LVL_TOP,
        layer_kind:   1'b0,
        phase:        PH_TAG,
        pending:      ACT_SKIP,
        emit_payload: 1'b0,
        finished:     1'b0,
        status:       ST_RUN
    };

endpackage

// File: rtl/nbe_step.sv
// Next-state logic of the parser for one file byte.
module nbe_step #(
    parameter int POS_BITS         = nbe_pkg::POS_BITS_DEF,
    parameter int VARINT_MAX_BYTES = nbe_pkg::VARINT_MAX_DEF,
    localparam int ACC_W = 7 * VARINT_MAX_BYTES,
    localparam int CNT_W = (VARINT_MAX_BYTES > 1) ? $clog2(VARINT_MAX_BYTES) : 1
) (
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  nbe_pkg::ctrl_t      ctrl,
    input  logic [POS_BITS-1:0] position,
    input  logic [POS_BITS-1:0] level_end1,
    input  logic [POS_BITS-1:0] level_end2,
    input  logic [ACC_W-1:0]    varint_acc,
    input  logic [CNT_W-1:0]    varint_count,
    input  logic [POS_BITS-1:0] bytes_left,
    output nbe_pkg::ctrl_t      ctrl_next,
    output logic [POS_BITS-1:0] position_next,
    output logic [POS_BITS-1:0] level_end1_next,
    output logic [POS_BITS-1:0] level_end2_next,
    output logic [ACC_W-1:0]    varint_acc_next,
    output logic [CNT_W-1:0]    varint_count_next,
    output logic [POS_BITS-1:0] bytes_left_next,
    output logic [7:0]          out_byte,
    output logic                has_byte,
    output nbe_pkg::status_t    status
);
    import nbe_pkg::*;

    localparam int SUM_W = ((POS_BITS > ACC_W) ? POS_BITS : ACC_W) + 1;
    localparam int FN_W  = ACC_W - 3;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [CNT_W+2:0]    shamt;
    logic [ACC_W-1:0]    shifted;
    logic [ACC_W-1:0]    value;
    logic [FN_W-1:0]     fn;
    logic [POS_BITS-1:0] pos_inc;
    logic [POS_BITS-1:0] cur_end;

    assign shamt   = {3'b000, varint_count} * (CNT_W + 3)'(7);
    assign shifted = {{(ACC_W-7){1'b0}}, in_byte[6:0]} << shamt;
    assign value   = varint_acc | shifted;
    assign fn      = value[ACC_W-1:3];
    assign pos_inc = position + 1'b1;
    assign cur_end = (ctrl.level == LVL_BLOB) ? level_end2 : level_end1;

    always_comb begin
        ctrl_t               nx;
        logic                start_len;
        logic [ACC_W-1:0]    len;
        logic [SUM_W-1:0]    len_sum;
        logic [SUM_W-1:0]    limit;

        nx                = ctrl;
        position_next     = position;
        level_end1_next   = level_end1;
        level_end2_next   = level_end2;
        varint_acc_next   = varint_acc;
        varint_count_next = varint_count;
        bytes_left_next   = bytes_left;
        out_byte          = 8'h00;
        has_byte          = 1'b0;
        start_len         = 1'b0;
        len               = value;
        len_sum           = '0;
        limit             = '0;

        if (!ctrl.finished) begin
            if (position == POS_MAX ||
                (ctrl.level != LVL_TOP && position >= cur_end)) begin
                nx.finished = 1'b1;
                nx.status   = ST_OVERRUN;
            end else begin
                position_next = pos_inc;
                if (ctrl.phase == PH_SKIP) begin
                    if (ctrl.emit_payload) begin
                        out_byte = in_byte;
                        has_byte = 1'b1;
                    end
                    bytes_left_next = bytes_left - 1'b1;
                    if (bytes_left == POS_BITS'(1))
                        nx.phase = PH_TAG;
                end else if (in_byte[7]) begin
                    if (varint_count == CNT_W'(VARINT_MAX_BYTES - 1)) begin
                        nx.finished = 1'b1;
                        nx.status   = ST_VARINT;
                    end else begin
                        varint_acc_next   = value;
                        varint_count_next = varint_count + 1'b1;
                    end
                end else begin
                    varint_acc_next   = '0;
                    varint_count_next = '0;
                    if (ctrl.phase == PH_TAG) begin
                        nx.phase = PH_TAG;
                        if (ctrl.level == LVL_TOP) begin
                            if (in_last) begin
                                nx.finished = 1'b1;
                                nx.status   = ST_OK;
                            end else if (value[2:0] != WIRE_LEN) begin
                                nx.finished = 1'b1;
                                nx.status   = ST_WIRE;
                            end else if (fn == FN_W'(FN_V1_LAYER)) begin
                                nx.pending = ACT_PUSH_V1;
                                nx.phase   = PH_LEN;
                            end else if (fn == FN_W'(FN_LAYER)) begin
                                nx.pending = ACT_PUSH_LAYER;
                                nx.phase   = PH_LEN;
                            end else if (fn == FN_W'(1) ||
                                         (fn >= FN_W'(3) && fn <= FN_W'(7))) begin
                                nx.pending = ACT_SKIP;
                                nx.phase   = PH_LEN;
                            end else begin
                                nx.finished = 1'b1;
                                nx.status   = ST_FIELD;
                            end
                        end else if (value == '0) begin
                            // zero tag: ignored in a V1 layer, ends the parse in a Layer or blob level
                            if (!(ctrl.level == LVL_LAYER && !ctrl.layer_kind)) begin
                                nx.finished = 1'b1;
                                nx.status   = ST_OK;
                            end
                        end else if (pos_inc == cur_end) begin
                            // tag lands on the level end: level closes below
                        end else if (ctrl.level == LVL_LAYER && !ctrl.layer_kind) begin
                            if (fn == FN_W'(FN_V1_VALUE)) begin
                                nx.phase = PH_VALUE;
                            end else if (fn == FN_W'(FN_V1_BLOB)) begin
                                nx.pending = ACT_PUSH_BLOB;
                                nx.phase   = PH_LEN;
                            end else if (fn == FN_W'(FN_V1_FIXED)) begin
                                nx.pending = ACT_SKIP;
                                start_len  = 1'b1;
                                len        = ACC_W'(FIXED32_LEN);
                            end else begin
                                nx.pending = ACT_EMIT;
                                nx.phase   = PH_LEN;
                            end
                        end else if (ctrl.level == LVL_LAYER) begin
                            nx.pending = (fn == FN_W'(FN_LAYER_BLOB)) ? ACT_PUSH_BLOB
                                                                      : ACT_SKIP;
                            nx.phase   = PH_LEN;
                        end else begin
                            if (fn >= FN_W'(1) && fn <= FN_W'(4)) begin
                                nx.phase = PH_VALUE;
                            end else begin
                                nx.pending = (fn == FN_W'(FN_BLOB_DATA)) ? ACT_EMIT
                                                                         : ACT_SKIP;
                                nx.phase   = PH_LEN;
                            end
                        end
                    end else if (ctrl.phase == PH_LEN) begin
                        start_len = 1'b1;
                    end else begin
                        nx.phase = PH_TAG;
                    end
                end

                // length of a field or nested level
                if (start_len) begin
                    len_sum = SUM_W'(pos_inc) + SUM_W'(len);
                    limit   = (ctrl.level != LVL_TOP) ? SUM_W'(cur_end) : SUM_W'(POS_MAX);
                    if (len_sum > limit) begin
                        nx.finished = 1'b1;
                        nx.status   = ST_OVERRUN;
                    end else if (nx.pending == ACT_PUSH_V1 || nx.pending == ACT_PUSH_LAYER ||
                                 nx.pending == ACT_PUSH_BLOB) begin
                        if (ctrl.level == LVL_TOP) begin
                            nx.level        = LVL_LAYER;
                            level_end1_next = len_sum[POS_BITS-1:0];
                        end else if (ctrl.level == LVL_LAYER) begin
                            nx.level        = LVL_BLOB;
                            level_end2_next = len_sum[POS_BITS-1:0];
                        end
                        if (nx.pending == ACT_PUSH_V1)
                            nx.layer_kind = 1'b0;
                        else if (nx.pending == ACT_PUSH_LAYER)
                            nx.layer_kind = 1'b1;
                        nx.phase = PH_TAG;
                    end else begin
                        nx.emit_payload = (nx.pending == ACT_EMIT);
                        if (len == '0) begin
                            nx.phase = PH_TAG;
                        end else begin
                            bytes_left_next = POS_BITS'(len);
                            nx.phase        = PH_SKIP;
                        end
                    end
                end

                // close levels that end here, innermost first
                if (!nx.finished && nx.phase == PH_TAG) begin
                    if (nx.level == LVL_BLOB && pos_inc == level_end2_next)
                        nx.level = LVL_LAYER;
                    if (nx.level == LVL_LAYER && pos_inc == level_end1_next)
                        nx.level = LVL_TOP;
                end

                if (!nx.finished && in_last) begin
                    nx.finished = 1'b1;
                    nx.status   = (nx.level == LVL_TOP && nx.phase == PH_TAG) ? ST_OK
                                                                              : ST_OVERRUN;
                end
            end
        end

        ctrl_next = nx;
        status    = nx.finished ? nx.status : ST_RUN;
    end

endmodule

// File: rtl/nested_protobuf_blob_extractor_top.sv
// Top level of the nested blob extractor: handshake, state and result registers.
//
// Takes a serialized model file one byte per transfer on the s_ channel
// (s_tdata = byte, s_tlast = final byte of the file) and returns exactly one
// result per byte on the m_ channel: the payload byte when one is extracted,
// a has-byte flag and the parse status (0 running, 1 success, 2 varint too
// long, 3 bad wire type, 4 bad top-level field, 5 overrun or truncation).
// Once a final status appears, all later bytes report it with no payload,
// until reset.
// A byte accepted into the input register passes through the parser into the
// result register, from which its result transfer happens.
// Throughput: one byte per cycle while m_tready stays high; the parser state
// updates once per byte between the input register and the result register.
// When m_tready is low the result register holds, one more byte waits in the
// input register, and s_tready drops after that.
// Reset (aresetn low, synchronous) returns the parser to the top level,
// position zero, and empties both registers.
module nested_protobuf_blob_extractor_top #(
    parameter int POS_BITS         = nbe_pkg::POS_BITS_DEF,
    parameter int VARINT_MAX_BYTES = nbe_pkg::VARINT_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,   // last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nbe_pkg::OUT_TDATA_W-1:0] m_tdata    // [7:0] out_byte, [8] has_byte,
                                                       // [11:9] status, [15:12] zero
);
    import nbe_pkg::*;

    localparam int ACC_W = 7 * VARINT_MAX_BYTES;
    localparam int CNT_W = (VARINT_MAX_BYTES > 1) ? $clog2(VARINT_MAX_BYTES) : 1;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                out_has_reg;
    status_t             out_status_reg;

    ctrl_t               ctrl_reg, ctrl_next;
    logic [POS_BITS-1:0] position_reg, position_next;
    logic [POS_BITS-1:0] level_end1_reg, level_end1_next;
    logic [POS_BITS-1:0] level_end2_reg, level_end2_next;
    logic [ACC_W-1:0]    varint_acc_reg, varint_acc_next;
    logic [CNT_W-1:0]    varint_count_reg, varint_count_next;
    logic [POS_BITS-1:0] bytes_left_reg, bytes_left_next;

    logic [7:0]          res_byte;
    logic                res_has;
    status_t             res_status;

    logic                out_free;
    logic                advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_status_reg, out_has_reg, out_byte_reg};

    nbe_step #(
        .POS_BITS         (POS_BITS),
        .VARINT_MAX_BYTES (VARINT_MAX_BYTES)
    ) u_step (
        .in_byte           (in_byte_reg),
        .in_last           (in_last_reg),
        .ctrl              (ctrl_reg),
        .position          (position_reg),
        .level_end1        (level_end1_reg),
        .level_end2        (level_end2_reg),
        .varint_acc        (varint_acc_reg),
        .varint_count      (varint_count_reg),
        .bytes_left        (bytes_left_reg),
        .ctrl_next         (ctrl_next),
        .position_next     (position_next),
        .level_end1_next   (level_end1_next),
        .level_end2_next   (level_end2_next),
        .varint_acc_next   (varint_acc_next),
        .varint_count_next (varint_count_next),
        .bytes_left_next   (bytes_left_next),
        .out_byte          (res_byte),
        .has_byte          (res_has),
        .status            (res_status)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // parser state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            ctrl_reg         <= CTRL_RESET;
            position_reg     <= '0;
            level_end1_reg   <= '0;
            level_end2_reg   <= '0;
            varint_acc_reg   <= '0;
            varint_count_reg <= '0;
            bytes_left_reg   <= '0;
        end else begin
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance) begin
                ctrl_reg         <= ctrl_next;
                position_reg     <= position_next;
                level_end1_reg   <= level_end1_next;
                level_end2_reg   <= level_end2_next;
                varint_acc_reg   <= varint_acc_next;
                varint_count_reg <= varint_count_next;
                bytes_left_reg   <= bytes_left_next;
            end
        end
        if (advance) begin
            out_byte_reg   <= res_byte;
            out_has_reg    <= res_has;
            out_status_reg <= res_status;
        end
    end

`ifndef SYNTH
    a_finished_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.finished |=> ctrl_reg.finished)
        else $error("parser left the finished state");

    a_pos_in_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctrl_reg.finished && ctrl_reg.level == LVL_LAYER) |-> position_reg <= level_end1_reg)
        else $error("position beyond end of layer");

    a_blob_in_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctrl_reg.finished && ctrl_reg.level == LVL_BLOB) |->
            (position_reg <= level_end2_reg && level_end2_reg <= level_end1_reg))
        else $error("blob level not nested inside layer");

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending byte lost during stall");
`endif

endmodule
